// ===== rtl/aes_kexp_pkg.sv =====
// ----------------------------------------------------------------------------
// AES key expansion package
// Shared types, constants and the S-box for the key schedule.
// ----------------------------------------------------------------------------
package aes_kexp_pkg;

    typedef enum logic [1:0] {
        KS_128 = 2'd0,
        KS_192 = 2'd1,
        KS_256 = 2'd2,
        KS_RSV = 2'd3
    } t_key_size;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WORK = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
            8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
            8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
            8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
            8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
            8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
            8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
            8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
            8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
            8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
            8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
            8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
            8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
            8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
            8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
            8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
            8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// ===== rtl/aes_kexp_if.sv =====
// ----------------------------------------------------------------------------
// AES key expansion channels
// Key input channel and round key output channel, valid/ready.
// ----------------------------------------------------------------------------
interface aes_kexp_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_part0;
    logic [63:0] key_part1;
    logic [63:0] key_part2;
    logic [63:0] key_part3;
    modport source (output valid, key_part0, key_part1, key_part2, key_part3,
                    input ready);
    modport sink   (input valid, key_part0, key_part1, key_part2, key_part3,
                    output ready);
endinterface

interface aes_kexp_rk_if;
    logic        valid;
    logic        ready;
    logic [3:0]  round_index;
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
    logic        last_round;
    modport source (output valid, round_index, round_key_high, round_key_low,
                    last_round, input ready);
    modport sink   (input valid, round_index, round_key_high, round_key_low,
                    last_round, output ready);
endinterface

// ===== rtl/aes_key_expansion.sv =====
// ----------------------------------------------------------------------------
// AES key expansion
// Expands a 128/192/256-bit cipher key into the full round key schedule.
// ----------------------------------------------------------------------------
// Usage:
//   i_key  : one cipher key per beat; key_size (i_cfg_we/i_cfg_data) picks
//            128, 192 or 256 bits, code 3 acts as 256.
//   o_rk   : 11, 13 or 15 round key beats, round_index counting up,
//            last_round set on the final one.
// One shared word unit (rotate, S-box, rcon, XOR) makes one key word per
// cycle, held in an eight-word ring. After every four words the round key
// is shown on o_rk and the unit waits until that beat is taken.
// i_key.ready is low from key accept until the last round key beat is taken.
// Reset returns to idle with key_size 128 and no output beat pending.
// A stall on o_rk simply holds the sequencer in place.
// ----------------------------------------------------------------------------
module aes_key_expansion
    import aes_kexp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    aes_kexp_key_if.sink   i_key,
    aes_kexp_rk_if.source  o_rk
);

    t_state      r_state, n_state;
    t_key_size   r_key_size;
    logic [31:0] r_ring [8];
    logic [31:0] r_key [8];
    logic [7:0]  r_rcon, n_rcon;
    logic [5:0]  r_cnt, n_cnt;
    logic [3:0]  r_round, n_round;
    logic [2:0]  r_pos, n_pos;      // word index modulo nk
    logic [3:0]  nk, rounds;
    logic [31:0] w_prev, w_sub, w_new;
    logic        we_ring;

    always_comb begin
        unique case (r_key_size)
            KS_128:  begin nk = 4'd4; rounds = 4'd11; end
            KS_192:  begin nk = 4'd6; rounds = 4'd13; end
            default: begin nk = 4'd8; rounds = 4'd15; end
        endcase
    end

    // shared word unit
    always_comb begin
        w_prev = r_ring[3'(r_cnt - 6'd1)];
        w_sub  = sbox_word((r_pos == 3'd0) ? {w_prev[23:0], w_prev[31:24]} : w_prev);
        if (r_cnt < {2'b00, nk}) begin
            w_new = r_key[r_cnt[2:0]];
        end else if (r_pos == 3'd0) begin
            w_new = w_sub ^ {r_rcon, 24'd0} ^ r_ring[3'(r_cnt - 6'(nk))];
        end else if (nk == 4'd8 && r_pos == 3'd4) begin
            w_new = w_sub ^ r_ring[3'(r_cnt - 6'(nk))];
        end else begin
            w_new = w_prev ^ r_ring[3'(r_cnt - 6'(nk))];
        end
    end

    always_comb begin
        n_state = r_state;
        n_rcon  = r_rcon;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_pos   = r_pos;
        we_ring = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_key.valid) begin
                    n_state = ST_WORK;
                    n_rcon  = 8'h01;
                    n_cnt   = '0;
                    n_round = '0;
                    n_pos   = '0;
                end
            end
            ST_WORK: begin
                we_ring = 1'b1;
                n_cnt   = r_cnt + 6'd1;
                n_pos   = ({1'b0, r_pos} + 4'd1 == nk) ? 3'd0 : r_pos + 3'd1;
                if (r_cnt >= {2'b00, nk} && r_pos == 3'd0) begin
                    n_rcon = {r_rcon[6:0], 1'b0} ^ (r_rcon[7] ? 8'h1b : 8'h00);
                end
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_rk.ready) begin
                    n_round = r_round + 4'd1;
                    n_state = (r_round + 4'd1 == rounds) ? ST_IDLE : ST_WORK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_key_size <= KS_128;
            r_rcon     <= 8'h01;
            r_cnt      <= '0;
            r_round    <= '0;
            r_pos      <= '0;
        end else begin
            r_state <= n_state;
            r_rcon  <= n_rcon;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                r_key_size <= t_key_size'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_key.valid) begin
            r_key <= '{i_key.key_part0[63:32], i_key.key_part0[31:0],
                       i_key.key_part1[63:32], i_key.key_part1[31:0],
                       i_key.key_part2[63:32], i_key.key_part2[31:0],
                       i_key.key_part3[63:32], i_key.key_part3[31:0]};
        end
        if (we_ring) begin
            r_ring[r_cnt[2:0]] <= w_new;
        end
    end

    assign i_key.ready         = (r_state == ST_IDLE);
    assign o_rk.valid          = (r_state == ST_EMIT);
    assign o_rk.round_index    = r_round;
    assign o_rk.round_key_high = {r_ring[3'(r_cnt - 6'd4)], r_ring[3'(r_cnt - 6'd3)]};
    assign o_rk.round_key_low  = {r_ring[3'(r_cnt - 6'd2)], r_ring[3'(r_cnt - 6'd1)]};
    assign o_rk.last_round     = (r_round + 4'd1 == rounds);

    a_emit_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rk.valid |-> r_cnt[1:0] == 2'd0 && r_cnt == {r_round, 2'b00} + 6'd4)
        else $error("round key emitted off a four-word boundary");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rk.valid || r_state == ST_WORK) |-> !i_key.ready)
        else $error("key accepted while schedule in progress");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rk.valid && o_rk.ready && o_rk.last_round) |=> r_state == ST_IDLE)
        else $error("sequencer did not return to idle after last round key");

endmodule
